FILE: design/swm_pkg.sv
package swm_pkg;

   // Default configuration of the filter
   localparam int WINDOW_MAX_DEF   = 64;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int WINDOW_SIZE_RST  = 3;

   // Per-cycle control broadcast to every cell of the chain
   typedef struct packed {
      logic advance;   // an item is taken this cycle, shift the chain
      logic clear;     // end of stream, drop every held sample
   } cell_ctrl_type;

endpackage

FILE: design/swm_req_if.sv
interface swm_req_if #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

FILE: design/swm_rsp_if.sv
interface swm_rsp_if #(
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] window_max;

   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

FILE: design/swm_cell.sv
// One cell of the running-max chain: cell i holds the max of the newest i+1
// samples of the stream.
module swm_cell
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cell_ctrl_type                  ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic                           prev_valid,
   input  logic signed [SAMPLE_WIDTH-1:0] prev_max,
   output logic                           valid,
   output logic signed [SAMPLE_WIDTH-1:0] max_value,
   output logic signed [SAMPLE_WIDTH-1:0] next_max
);

   logic                           valid_ff;
   logic                           valid_in;
   logic signed [SAMPLE_WIDTH-1:0] max_ff;

   always_comb begin
      if (prev_valid && (prev_max > sample)) begin
         next_max = prev_max;
      end else begin
         next_max = sample;
      end
      valid_in = valid_ff;
      if (ctrl.advance) begin
         valid_in = prev_valid;
      end
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         max_ff <= next_max;
      end
   end

   assign valid     = valid_ff;
   assign max_value = max_ff;

endmodule

FILE: design/sliding_window_maximum_top.sv
// Sliding-window maximum: the result is registered; rsp valid rises in the cycle after item accept.
// Throughput 1 item per cycle while the rsp side takes results; every cell
// of the chain does one compare per cycle and the result mux reads one cell.
// Reset (synchronous, active high) empties the chain, clears the sample
// count and span, sets window_size to 3. No clearing pass: ready after reset.
module sliding_window_maximum_top
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   localparam int CNT_W       = $clog2(WINDOW_MAX + 1),
   localparam int IDX_W       = $clog2(WINDOW_MAX)
) (
   input  logic             clock,
   input  logic             reset,
   swm_req_if.sink          req,
   swm_rsp_if.source        rsp,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);

   // The chain keeps, in cell i, the max of the newest i+1 samples of the
   // current stream. A new sample s makes cell i take max(s, old cell i-1),
   // so after the step cell j-1 holds the max over the last j samples.
   // The window start only ever moves forward: a shrink drops old samples
   // for good, and a later grow does not bring them back. The span tracks
   // that, span = min(span + 1, k) per item, and the result reads cell
   // span-1, which is the front of the monotonic queue when a result is due.

   logic [CNT_W-1:0] window_ff;
   logic [CNT_W-1:0] window_in;
   logic [CNT_W-1:0] seen_ff;
   logic [CNT_W-1:0] seen_in;
   logic [CNT_W-1:0] seen_next;
   logic [CNT_W-1:0] span_ff;
   logic [CNT_W-1:0] span_in;
   logic [CNT_W-1:0] span_next;
   logic [CNT_W-1:0] k_eff;
   logic [IDX_W-1:0] sel;
   logic             accept;
   logic             emit;
   cell_ctrl_type    ctrl;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff;

   logic                           cell_valid [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] cell_max   [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] cell_next  [WINDOW_MAX];

   // Input is taken whenever the output register is empty or draining.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign ctrl.advance = accept;
   assign ctrl.clear   = accept && req.last_sample;

   // Window size: zero acts as 1, anything above the chain length saturates.
   always_comb begin
      if (window_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (window_ff > CNT_W'(WINDOW_MAX)) begin
         k_eff = CNT_W'(WINDOW_MAX);
      end else begin
         k_eff = window_ff;
      end
   end

   // Sample count stops rising at the current window size; a size raised
   // mid-stream waits for the count to climb again.
   always_comb begin
      seen_next = seen_ff;
      if (seen_ff < k_eff) begin
         seen_next = seen_ff + CNT_W'(1);
      end
      emit = (seen_next >= k_eff);

      // Span of samples still inside the window, capped by the current size
      if (span_ff < k_eff) begin
         span_next = span_ff + CNT_W'(1);
      end else begin
         span_next = k_eff;
      end
      sel = IDX_W'(span_next - CNT_W'(1));

      seen_in = seen_ff;
      span_in = span_ff;
      if (accept) begin
         seen_in = req.last_sample ? '0 : seen_next;
         span_in = req.last_sample ? '0 : span_next;
      end

      window_in = window_ff;
      if (csr_we) begin
         window_in = csr_wdata;
      end

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= CNT_W'(WINDOW_SIZE_RST);
         seen_ff      <= '0;
         span_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         seen_ff      <= seen_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register: the post-step value of the cell at the window span.
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= cell_next[sel];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.window_max = rsp_data_ff;

   // Cell 0 always restarts from the new sample alone.
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
         swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .sample     (req.sample),
            .prev_valid (1'b1),
            .prev_max   (req.sample),
            .valid      (cell_valid[i]),
            .max_value  (cell_max[i]),
            .next_max   (cell_next[i])
         );
      end else begin : g_body
         swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .sample     (req.sample),
            .prev_valid (cell_valid[i-1]),
            .prev_max   (cell_max[i-1]),
            .valid      (cell_valid[i]),
            .max_value  (cell_max[i]),
            .next_max   (cell_next[i])
         );
      end
   end

endmodule
